// File: design/rpa_pkg.sv
// Package for the refcounted page allocator: sizes, operation and status codes,
// and the queue entry type shared by the front and back parts. No dependencies.
package rpa_pkg;

  localparam int unsigned Pages     = 32768;
  localparam int unsigned PageBytes = 4096;
  localparam int unsigned RefBits   = 8;
  localparam int unsigned AddrW     = 40;
  localparam int unsigned IdxW      = $clog2(Pages);
  localparam int unsigned TopW      = $clog2(Pages + 1);
  localparam int unsigned OffW      = $clog2(PageBytes);
  localparam int unsigned FreeW     = 16;
  localparam int unsigned OpW       = 3;
  localparam int unsigned StatW     = 2;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [OpW-1:0] OpInit    = 3'd0;
  localparam logic [OpW-1:0] OpAlloc   = 3'd1;
  localparam logic [OpW-1:0] OpFree    = 3'd2;
  localparam logic [OpW-1:0] OpRefUp   = 3'd3;
  localparam logic [OpW-1:0] OpRefDown = 3'd4;
  localparam logic [OpW-1:0] OpCow     = 3'd5;
  localparam logic [OpW-1:0] OpQuery   = 3'd6;

  localparam logic [StatW-1:0] StOk     = 2'd0;
  localparam logic [StatW-1:0] StBadAdr = 2'd1;
  localparam logic [StatW-1:0] StOom    = 2'd2;
  localparam logic [StatW-1:0] StDouble = 2'd3;

  localparam logic [CfgIdxW-1:0] RegMemBase = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFirst   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMemTop  = 2'd2;

  // Classified command handed from front to back
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             addr_ok;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] addr;
  } cmd_t;

  localparam int unsigned QDepth = 2;

endpackage

// File: design/rpa_front.sv
// Front part: accepts operations, checks the page address, queues commands.
// Depends on rpa_pkg.
module rpa_front import rpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [AddrW-1:0] mem_base_i,
  input  logic [AddrW-1:0] first_i,
  input  logic [AddrW-1:0] mem_top_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  cmd_t             q_q [QDepth];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [AddrW-1:0] off;
  logic             ok;
  cmd_t             cmd_new;
  logic             push, pop;

  // address check: alignment, offset alignment, bounds, index range
  always_comb begin
    off = addr_i - mem_base_i;
    ok  = (addr_i[OffW-1:0] == '0) && (off[OffW-1:0] == '0)
          && (addr_i >= mem_base_i) && (addr_i >= first_i)
          && (addr_i < mem_top_i) && (off[AddrW-1:OffW+IdxW] == '0);
    cmd_new.op      = op_i;
    cmd_new.addr_ok = ok;
    cmd_new.idx     = off[OffW+IdxW-1:OffW];
    cmd_new.addr    = addr_i;
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= cmd_new;
  end

endmodule

// File: design/rpa_back.sv
// Back part: count memory, free stack and the sequencer that carries out commands.
// Depends on rpa_pkg.
module rpa_back import rpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic [AddrW-1:0]  mem_base_i,
  input  logic [AddrW-1:0]  first_i,
  input  logic [AddrW-1:0]  mem_top_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [StatW-1:0]  status_o,
  output logic [AddrW-1:0]  res_addr_o,
  output logic [RefBits-1:0] ref_o,
  output logic [FreeW-1:0]  free_o,
  output logic              busy_o
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SExec  = 3'd3;
  localparam logic [2:0] SCowWr = 3'd4;
  localparam logic [2:0] SInit  = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  localparam logic [RefBits-1:0] RefMax = '1;
  localparam logic [RefBits-1:0] RefOne = RefBits'(1);

  logic [RefBits-1:0] ref_mem [Pages];
  logic [IdxW-1:0]    stk_mem [Pages];

  logic [2:0]         st_q, st_d;
  cmd_t               cmd_q, cmd_d;
  logic [TopW-1:0]    top_q, top_d;
  logic [TopW-1:0]    walk_q, walk_d;
  logic [RefBits-1:0] rdat_q;
  logic [IdxW-1:0]    sdat_q;
  logic [StatW-1:0]   stat_q, stat_d;
  logic [AddrW-1:0]   radr_q, radr_d;
  logic [RefBits-1:0] rcnt_q, rcnt_d;
  logic [IdxW-1:0]    nidx_q, nidx_d;

  logic               rwe, swe;
  logic [IdxW-1:0]    rwa, swa, sra, rra;
  logic [RefBits-1:0] rwd;
  logic [IdxW-1:0]    swd;
  logic [AddrW-1:0]   wpage;
  logic [AddrW:0]     wend;
  logic               elig, can_push, can_pop;
  logic [RefBits-1:0] dec;

  assign can_push = (top_q < TopW'(Pages));
  assign can_pop  = (top_q != '0);
  assign dec      = rdat_q - RefOne;
  // init walk page address and eligibility
  assign wpage    = mem_base_i + {walk_q[IdxW-1:0], {OffW{1'b0}}};
  assign wend     = {1'b0, mem_base_i} + {1'b0, walk_q[IdxW-1:0], {OffW{1'b0}}}
                    + (AddrW+1)'(PageBytes);
  // pages past the top of the 40-bit space are never eligible
  assign elig     = (mem_base_i[OffW-1:0] == '0)
                    && ({1'b0, wpage} == wend - (AddrW+1)'(PageBytes))
                    && (wpage >= first_i) && (wend <= {1'b0, mem_top_i});

  assign cmd_ready_o = (st_q == SIdle);
  assign res_valid_o = (st_q == SOut);
  assign status_o    = stat_q;
  assign res_addr_o  = radr_q;
  assign ref_o       = rcnt_q;
  assign free_o      = FreeW'(top_q);
  assign busy_o      = (st_q != SIdle);
  assign rra         = cmd_q.idx;
  assign sra         = IdxW'(top_q - TopW'(1));

  // sequencer
  always_comb begin
    st_d = st_q; cmd_d = cmd_q; top_d = top_q; walk_d = walk_q;
    stat_d = stat_q; radr_d = radr_q; rcnt_d = rcnt_q; nidx_d = nidx_q;
    rwe = 1'b0; rwa = cmd_q.idx; rwd = '0;
    swe = 1'b0; swa = IdxW'(top_q); swd = cmd_q.idx;
    case (st_q)
      SClear: begin
        rwe = 1'b1; rwa = walk_q[IdxW-1:0];
        walk_d = walk_q + TopW'(1);
        if (walk_q == TopW'(Pages - 1)) begin
          walk_d = '0; st_d = SIdle;
        end
      end
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i; st_d = SRead;
        end
      end
      SRead: begin
        stat_d = StOk; radr_d = '0; rcnt_d = '0; st_d = SExec;
        if (cmd_q.op == OpInit) begin
          top_d = '0; walk_d = '0; st_d = SInit;
        end
      end
      SExec: begin
        st_d = SOut;
        if (cmd_q.op == OpAlloc) begin
          if (can_pop) begin
            top_d = top_q - TopW'(1);
            rwe = 1'b1; rwa = sdat_q; rwd = RefOne;
            radr_d = mem_base_i + {sdat_q, {OffW{1'b0}}}; rcnt_d = RefOne;
          end else stat_d = StOom;
        end else if (cmd_q.op == OpFree || cmd_q.op == OpRefUp || cmd_q.op == OpRefDown
                     || cmd_q.op == OpCow || cmd_q.op == OpQuery) begin
          if (!cmd_q.addr_ok) stat_d = StBadAdr;
          else begin
            case (cmd_q.op)
              OpFree: begin
                if (rdat_q == '0) stat_d = StDouble;
                else begin
                  rwe = 1'b1; rwd = dec; rcnt_d = dec;
                  if (dec == '0 && can_push) begin
                    swe = 1'b1; top_d = top_q + TopW'(1);
                  end
                end
              end
              OpRefUp: begin
                rwd = (rdat_q == RefMax) ? rdat_q : rdat_q + RefOne;
                rwe = 1'b1; rcnt_d = rwd;
              end
              OpRefDown: begin
                rwd = (rdat_q == '0) ? rdat_q : dec;
                rwe = 1'b1; rcnt_d = rwd;
              end
              OpCow: begin
                if (rdat_q <= RefOne) begin
                  radr_d = cmd_q.addr; rcnt_d = rdat_q;
                end else if (can_pop) begin
                  // new page set to one here, old page dropped next cycle
                  top_d = top_q - TopW'(1);
                  rwe = 1'b1; rwa = sdat_q; rwd = RefOne; nidx_d = sdat_q;
                  radr_d = mem_base_i + {sdat_q, {OffW{1'b0}}};
                  rcnt_d = (sdat_q == cmd_q.idx) ? '0 : RefOne;
                  st_d = SCowWr;
                end else begin
                  stat_d = StOom; rcnt_d = rdat_q;
                end
              end
              default: rcnt_d = rdat_q;
            endcase
          end
        end
      end
      SCowWr: begin
        // old page loses one reference; a page handed back to itself ends at zero
        rwe = 1'b1; rwd = (nidx_q == cmd_q.idx) ? '0 : dec; st_d = SOut;
      end
      SInit: begin
        rwe = 1'b1; rwa = walk_q[IdxW-1:0]; rwd = '0;
        swd = walk_q[IdxW-1:0];
        if (elig && can_push) begin
          swe = 1'b1; top_d = top_q + TopW'(1);
        end
        walk_d = walk_q + TopW'(1);
        if (walk_q == TopW'(Pages - 1)) begin
          walk_d = '0; st_d = SOut;
        end
      end
      SOut: begin
        if (res_ready_i) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SClear;
      top_q  <= '0;
      walk_q <= '0;
    end else begin
      st_q   <= st_d;
      top_q  <= top_d;
      walk_q <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    stat_q <= stat_d;
    radr_q <= radr_d;
    rcnt_q <= rcnt_d;
    nidx_q <= nidx_d;
  end

  // count memory
  always_ff @(posedge clk_i) begin
    if (rwe) ref_mem[rwa] <= rwd;
    rdat_q <= ref_mem[rra];
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if (swe) stk_mem[swa] <= swd;
    sdat_q <= stk_mem[sra];
  end

endmodule

// File: design/refcounted_page_allocator.sv
// Top level of the refcounted page allocator: config registers, front, back.
// Depends on rpa_pkg, rpa_front, rpa_back.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: operation, page_address
//  m_axis   | out       | tdata: status, result_address, ref_count, free_pages
//  cfg      | in        | cfg_idx_i, cfg_data_i
//
// Operations pass through the back sequencer as memory read, execute,
// optional copy write and result; init walks every page.
// After reset a clearing pass over every page zeroes the count memory; no
// transfer is taken from the queue then. The two-entry queue keeps accepting,
// until it is full, while the back part or the output stalls.
module refcounted_page_allocator import rpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,  // operation[2:0], page_address[42:3]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata,  // status[1:0], result_address[41:2],
                                              // ref_count[49:42], free_pages[65:50]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [AddrW-1:0]     cfg_data_i
);

  logic [AddrW-1:0]   base_q, first_q, top_q;
  logic               cmd_valid, cmd_ready, busy;
  cmd_t               cmd;
  logic [StatW-1:0]   status;
  logic [AddrW-1:0]   raddr;
  logic [RefBits-1:0] rcnt;
  logic [FreeW-1:0]   nfree;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 40'h0080000000;
      first_q <= 40'h0080200000;
      top_q   <= 40'h0088000000;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        RegMemBase: base_q  <= cfg_data_i;
        RegFirst:   first_q <= cfg_data_i;
        RegMemTop:  top_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[2:0]),
    .addr_i     (s_axis_tdata[42:3]),
    .mem_base_i (base_q),
    .first_i    (first_q),
    .mem_top_i  (top_q),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  rpa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .mem_base_i (base_q),
    .first_i    (first_q),
    .mem_top_i  (top_q),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .status_o   (status),
    .res_addr_o (raddr),
    .ref_o      (rcnt),
    .free_o     (nfree),
    .busy_o     (busy)
  );

  assign m_axis_tdata = {6'd0, nfree, rcnt, raddr, status};

`ifndef SYNTHESIS
  // the free count never exceeds the page count
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfree <= FreeW'(Pages)) else $error("free count out of range");
  // a result is only offered while the back part is working
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> busy) else $error("result without command");
  // bad address and double free carry neither an address nor a count
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == StBadAdr || status == StDouble))
    |-> (raddr == '0 && rcnt == '0)) else $error("error result with payload");
`endif

endmodule
